// ===== rtl/fdc_pkg.sv =====
// Shared types, constants and byte-wide CRC-32 / PN9 update functions
// for the frame decoder. Depends on nothing.
package fdc_pkg;

    localparam int HDR_BYTES = 12;
    localparam int MIN_FRAME = 13;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL  = 32'hFFFFFFFF;
    localparam logic [7:0]  MAGIC_A  = 8'h51;
    localparam logic [7:0]  MAGIC_B  = 8'h4B;
    localparam logic [8:0]  PN_SEED  = 9'h1FF;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_BAD_CRC   = 2'd3;

    localparam logic [0:0] REG_FRAME_BYTES   = 1'd0;
    localparam logic [0:0] REG_WHITEN_ENABLE = 1'd1;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic [1:0]  frame_status;
        logic [15:0] payload_length;
        logic [31:0] sequence_number;
    } fdc_result_t;

    typedef struct packed {
        logic [11:0] frame_bytes;
        logic        whiten_enable;
    } fdc_cfg_t;

    typedef struct packed {
        logic [8:0] lfsr;
        logic [7:0] pn;
    } fdc_pn_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] d);
        logic [31:0] c;
        c = crc_in ^ {24'd0, d};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic fdc_pn_t pn_byte(input logic [8:0] lfsr_in);
        fdc_pn_t r;
        logic    nb;
        r.lfsr = lfsr_in;
        r.pn   = 8'd0;
        for (int k = 0; k < 8; k++) begin
            nb     = r.lfsr[8] ^ r.lfsr[4];
            r.lfsr = {r.lfsr[7:0], nb};
            r.pn   = {r.pn[6:0], nb};
        end
        return r;
    endfunction

endpackage

// ===== rtl/fdc_apb_regs.sv =====
// APB configuration registers of the frame decoder: frame length and
// whitening enable. Depends on fdc_pkg.
module fdc_apb_regs (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output fdc_pkg::fdc_cfg_t cfg
);
    import fdc_pkg::*;

    logic [11:0] frame_bytes_reg;
    logic        whiten_enable_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bytes_reg   <= 12'd2048;
            whiten_enable_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2:2])
                REG_FRAME_BYTES:   frame_bytes_reg   <= pwdata[11:0];
                REG_WHITEN_ENABLE: whiten_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2:2])
            REG_FRAME_BYTES:   prdata = {20'd0, frame_bytes_reg};
            REG_WHITEN_ENABLE: prdata = {31'd0, whiten_enable_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.frame_bytes   = frame_bytes_reg;
    assign cfg.whiten_enable = whiten_enable_reg;

endmodule

// ===== rtl/fdc_frame_core.sv =====
// Per-frame parse state and the one-byte de-whiten, header parse and CRC
// update that produces one result per byte. Depends on fdc_pkg.
module fdc_frame_core #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  fdc_pkg::fdc_cfg_t    cfg,
    output fdc_pkg::fdc_result_t result
);
    import fdc_pkg::*;

    localparam int POS_W  = $clog2(MAX_FRAME_BYTES);
    localparam int FLEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W  = (FLEN_W > 16) ? FLEN_W : 16;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [8:0]       lfsr_reg;
    logic [31:0]      crc_reg, crc_next;
    logic             magic_reg, magic_next;
    logic [15:0]      len_reg, len_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      rcrc_reg, rcrc_next;

    fdc_pn_t          pn;
    logic [7:0]       d;
    logic [CMP_W-1:0] fb_ext, flen, maxpay, pos_ext;
    logic             len_ok, pay_pos, valid, done, crc_upd, crc_use_d;
    logic [1:0]       status;

    always_comb begin
        fb_ext = CMP_W'(cfg.frame_bytes);
        if (fb_ext > CMP_W'(MAX_FRAME_BYTES)) begin
            flen = CMP_W'(MAX_FRAME_BYTES);
        end else if (fb_ext < CMP_W'(MIN_FRAME)) begin
            flen = CMP_W'(MIN_FRAME);
        end else begin
            flen = fb_ext;
        end
        maxpay  = flen - CMP_W'(HDR_BYTES);
        pos_ext = CMP_W'(pos_reg);

        pn = pn_byte(lfsr_reg);
        d  = cfg.whiten_enable ? (rx_byte ^ pn.pn) : rx_byte;

        magic_next = magic_reg;
        if (pos_reg == POS_W'(0) && d != MAGIC_A) magic_next = 1'b0;
        if (pos_reg == POS_W'(1) && d != MAGIC_B) magic_next = 1'b0;

        len_next = len_reg;
        if (pos_reg == POS_W'(2)) len_next[7:0]  = d;
        if (pos_reg == POS_W'(3)) len_next[15:8] = d;

        seq_next = seq_reg;
        if (pos_reg >= POS_W'(4) && pos_reg < POS_W'(8)) begin
            seq_next = seq_reg | ({24'd0, d} << {pos_reg[1:0], 3'b000});
        end
        rcrc_next = rcrc_reg;
        if (pos_reg >= POS_W'(8) && pos_reg < POS_W'(HDR_BYTES)) begin
            rcrc_next = rcrc_reg | ({24'd0, d} << {pos_reg[1:0], 3'b000});
        end

        len_ok  = CMP_W'(len_next) <= maxpay;
        pay_pos = (pos_ext >= CMP_W'(HDR_BYTES))
               && ((pos_ext - CMP_W'(HDR_BYTES)) < CMP_W'(len_next));

        crc_use_d = (pos_reg < POS_W'(8)) || pay_pos;
        crc_upd   = (pos_reg < POS_W'(HDR_BYTES)) || pay_pos;
        crc_next  = crc_upd ? crc_byte(crc_reg, crc_use_d ? d : 8'd0) : crc_reg;

        valid = pay_pos && len_ok && magic_next;
        done  = pos_ext >= (flen - CMP_W'(1));

        if (!magic_next) begin
            status = ST_BAD_MAGIC;
        end else if (!len_ok) begin
            status = ST_BAD_LEN;
        end else if ((crc_next ^ CRC_ALL) != rcrc_next) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end

        pos_next = pos_reg + POS_W'(1);

        result.payload_valid   = valid;
        result.payload_byte    = valid ? d : 8'd0;
        result.frame_done      = done;
        result.frame_status    = done ? status : ST_OK;
        result.payload_length  = done ? len_next : 16'd0;
        result.sequence_number = done ? seq_next : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            lfsr_reg  <= PN_SEED;
            crc_reg   <= CRC_ALL;
            magic_reg <= 1'b1;
            len_reg   <= 16'd0;
            seq_reg   <= 32'd0;
            rcrc_reg  <= 32'd0;
        end else if (step) begin
            if (done) begin
                pos_reg   <= '0;
                lfsr_reg  <= PN_SEED;
                crc_reg   <= CRC_ALL;
                magic_reg <= 1'b1;
                len_reg   <= 16'd0;
                seq_reg   <= 32'd0;
                rcrc_reg  <= 32'd0;
            end else begin
                pos_reg   <= pos_next;
                lfsr_reg  <= pn.lfsr;
                crc_reg   <= crc_next;
                magic_reg <= magic_next;
                len_reg   <= len_next;
                seq_reg   <= seq_next;
                rcrc_reg  <= rcrc_next;
            end
        end
    end

endmodule

// ===== rtl/frame_decoder_crc32_dewhiten.sv =====
// Top level of the PN9 de-whitening frame decoder with CRC-32 check.
// Depends on fdc_pkg, fdc_apb_regs and fdc_frame_core.
//
//   Channel   Direction  Handshake          Content
//   s_        in         s_valid/s_ready    one received byte per transfer
//   m_        out        m_valid/m_ready    one result per received byte
//   APB       in         psel/penable       frame_bytes (0x0), whiten_enable (0x4)
//
// Each byte passes an input register, then the parse and CRC logic, then the
// result register, with the byte-wide CRC and PN9 update between the two
// registers; one transfer per cycle is sustained while m_ready stays high.
// Reset clears the frame state and both pipeline stages; no clearing pass.
// A stall on m_ready holds the result and backs up into the input register.
module frame_decoder_crc32_dewhiten #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic        m_frame_done,
    output logic [1:0]  m_frame_status,
    output logic [15:0] m_payload_length,
    output logic [31:0] m_sequence_number,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fdc_pkg::*;

    fdc_cfg_t    cfg;
    fdc_result_t core_result;
    fdc_result_t out_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic        out_adv, step;

    fdc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_adv = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && out_adv;
    assign s_ready = !in_valid_reg || out_adv;

    fdc_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step) begin
            out_reg <= core_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_payload_valid   = out_reg.payload_valid;
    assign m_payload_byte    = out_reg.payload_byte;
    assign m_frame_done      = out_reg.frame_done;
    assign m_frame_status    = out_reg.frame_status;
    assign m_payload_length  = out_reg.payload_length;
    assign m_sequence_number = out_reg.sequence_number;

endmodule

// ===== tb/fdc_frame_check_pkg.sv =====
// Scoreboard for the frame decoder test: a bit-exact predictor of the decoder
// and the queue of results it still awaits. Depends on fdc_pkg.
package fdc_frame_check_pkg;

    import fdc_pkg::*;

    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] c;
        c = crc ^ {24'd0, d};
        repeat (8) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] pn9_next(inout logic [8:0] state);
        logic [7:0] b;
        logic       fb;
        b = 8'd0;
        repeat (8) begin
            fb    = state[8] ^ state[4];
            state = {state[7:0], fb};
            b     = {b[6:0], fb};
        end
        return b;
    endfunction

    class frame_result_board;
        int unsigned frame_bytes_reg;
        bit          whiten_on;
        int unsigned max_frame;

        int unsigned frame_pos;
        logic [8:0]  lfsr;
        logic [31:0] crc;
        bit          magic_ok;
        logic [15:0] hdr_len;
        logic [31:0] hdr_seq;
        logic [31:0] hdr_crc;

        fdc_result_t awaited[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned payload_seen;
        int unsigned status_count[4];

        function new(int unsigned max_frame_bytes);
            max_frame       = max_frame_bytes;
            frame_bytes_reg = 2048;
            whiten_on       = 1'b0;
            failures        = 0;
            checked         = 0;
            payload_seen    = 0;
            foreach (status_count[i]) status_count[i] = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            frame_pos = 0;
            lfsr      = PN_SEED;
            crc       = CRC_ALL;
            magic_ok  = 1'b1;
            hdr_len   = 16'd0;
            hdr_seq   = 32'd0;
            hdr_crc   = 32'd0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [31:0] value);
            if (idx == REG_FRAME_BYTES) frame_bytes_reg = value[11:0];
            else if (idx == REG_WHITEN_ENABLE) whiten_on = value[0];
        endfunction

        function int unsigned effective_frame();
            if (frame_bytes_reg > max_frame) return max_frame;
            if (frame_bytes_reg < MIN_FRAME) return MIN_FRAME;
            return frame_bytes_reg;
        endfunction

        function void note_byte(logic [7:0] raw);
            int unsigned flen;
            int unsigned maxpay;
            logic [7:0]  pn;
            logic [7:0]  d;
            bit          len_ok;
            bit          in_payload;
            fdc_result_t r;
            flen   = effective_frame();
            maxpay = flen - HDR_BYTES;
            pn     = pn9_next(lfsr);
            d      = whiten_on ? (raw ^ pn) : raw;

            if (frame_pos == 0 && d != MAGIC_A) magic_ok = 1'b0;
            if (frame_pos == 1 && d != MAGIC_B) magic_ok = 1'b0;
            if (frame_pos == 2) hdr_len[7:0] = d;
            if (frame_pos == 3) hdr_len[15:8] = d;
            if (frame_pos >= 4 && frame_pos < 8) hdr_seq[8*(frame_pos-4) +: 8] = d;
            if (frame_pos >= 8 && frame_pos < 12) hdr_crc[8*(frame_pos-8) +: 8] = d;

            len_ok     = hdr_len <= maxpay;
            in_payload = frame_pos >= HDR_BYTES && (frame_pos - HDR_BYTES) < hdr_len;

            if (frame_pos < 8) crc = crc32_step(crc, d);
            else if (frame_pos < HDR_BYTES) crc = crc32_step(crc, 8'h00);
            else if (in_payload) crc = crc32_step(crc, d);

            r = '0;
            r.payload_valid = in_payload && len_ok && magic_ok;
            r.payload_byte  = r.payload_valid ? d : 8'h00;
            if (r.payload_valid) payload_seen++;
            r.frame_done = frame_pos >= flen - 1;
            if (r.frame_done) begin
                if (!magic_ok) r.frame_status = ST_BAD_MAGIC;
                else if (!len_ok) r.frame_status = ST_BAD_LEN;
                else if ((crc ^ CRC_ALL) != hdr_crc) r.frame_status = ST_BAD_CRC;
                else r.frame_status = ST_OK;
                r.payload_length  = hdr_len;
                r.sequence_number = hdr_seq;
                status_count[r.frame_status]++;
                restart_frame();
            end else begin
                frame_pos++;
            end
            awaited.push_back(r);
        endfunction

        function void check_result(fdc_result_t got);
            fdc_result_t want;
            checked++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result transfer with nothing awaited: %h", got);
                return;
            end
            want = awaited.pop_front();
            if (got.payload_valid !== want.payload_valid ||
                got.payload_byte !== want.payload_byte ||
                got.frame_done !== want.frame_done ||
                got.frame_status !== want.frame_status ||
                got.payload_length !== want.payload_length ||
                got.sequence_number !== want.sequence_number) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: result %0d expected pv=%b pb=%h done=%b st=%0d len=%h seq=%h",
                             checked, want.payload_valid, want.payload_byte, want.frame_done,
                             want.frame_status, want.payload_length, want.sequence_number);
                    $display("       actual          pv=%b pb=%h done=%b st=%0d len=%h seq=%h",
                             got.payload_valid, got.payload_byte, got.frame_done,
                             got.frame_status, got.payload_length, got.sequence_number);
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/frame_decoder_crc32_dewhiten_test.sv =====
// Self-checking test of frame_decoder_crc32_dewhiten: drives framed bytes and
// register writes, and checks every result against the scoreboard's prediction.
// Depends on fdc_pkg, fdc_frame_check_pkg and the decoder RTL.
module frame_decoder_crc32_dewhiten_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fdc_pkg::*;
    import fdc_frame_check_pkg::*;

    localparam int MAX_FRAME   = 2048;
    localparam int LATENCY     = 2;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;

    typedef enum {FR_GOOD, FR_BAD_MAGIC, FR_LONG, FR_BAD_CRC, FR_NOISE} frame_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic        m_frame_done;
    logic [1:0]  m_frame_status;
    logic [15:0] m_payload_length;
    logic [31:0] m_sequence_number;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_result_board sb;
    logic [7:0]  tx_frame[$];
    int          tx_mode;
    int          rx_mode;
    bit          hold_req;
    int unsigned settings_used;

    frame_decoder_crc32_dewhiten #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload_valid(m_payload_valid),
        .m_payload_byte(m_payload_byte),
        .m_frame_done(m_frame_done),
        .m_frame_status(m_frame_status),
        .m_payload_length(m_payload_length),
        .m_sequence_number(m_sequence_number),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_len(int mode);
        int r;
        if (mode == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void build_frame(frame_kind_t kind, int unsigned plen, logic [31:0] seq);
        int unsigned flen;
        int unsigned body;
        logic [31:0] crc;
        logic [8:0]  pn_state;
        logic [7:0]  pay[$];
        flen = sb.effective_frame();
        tx_frame.delete();
        if (kind == FR_NOISE) begin
            repeat (flen) tx_frame.push_back(8'($urandom_range(0, 255)));
        end else begin
            tx_frame = '{MAGIC_A, MAGIC_B, plen[7:0], plen[15:8],
                         seq[7:0], seq[15:8], seq[23:16], seq[31:24]};
            crc = CRC_ALL;
            foreach (tx_frame[k]) crc = crc32_step(crc, tx_frame[k]);
            repeat (4) crc = crc32_step(crc, 8'h00);
            body = (plen < flen - HDR_BYTES) ? plen : flen - HDR_BYTES;
            repeat (body) pay.push_back(8'($urandom_range(0, 255)));
            foreach (pay[k]) crc = crc32_step(crc, pay[k]);
            crc = ~crc;
            if (kind == FR_BAD_CRC) crc[$urandom_range(0, 31)] ^= 1'b1;
            for (int k = 0; k < 4; k++) tx_frame.push_back(crc[8*k +: 8]);
            foreach (pay[k]) tx_frame.push_back(pay[k]);
            while (tx_frame.size() < flen) tx_frame.push_back(8'($urandom_range(0, 255)));
            if (kind == FR_BAD_MAGIC) begin
                tx_frame[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            end
        end
        if (sb.whiten_on) begin
            pn_state = PN_SEED;
            foreach (tx_frame[k]) tx_frame[k] ^= pn9_next(pn_state);
        end
    endfunction

    function automatic void random_frame();
        int unsigned maxpay;
        int unsigned plen;
        int          r;
        int          sel;
        frame_kind_t kind;
        logic [31:0] seq;
        maxpay = sb.effective_frame() - HDR_BYTES;
        r = $urandom_range(0, 99);
        if (r < 70) kind = FR_GOOD;
        else if (r < 78) kind = FR_BAD_MAGIC;
        else if (r < 86) kind = FR_LONG;
        else if (r < 95) kind = FR_BAD_CRC;
        else kind = FR_NOISE;
        sel = $urandom_range(0, 9);
        if (sel == 0) plen = 0;
        else if (sel == 1) plen = maxpay;
        else if (sel == 2) plen = $urandom_range(0, maxpay);
        else plen = $urandom_range(0, (maxpay < 24) ? maxpay : 24);
        if (kind == FR_LONG) begin
            if (sel < 3) plen = maxpay + 1;
            else if (sel < 6) plen = 65535;
            else plen = $urandom_range(maxpay + 1, 65535);
        end
        r = $urandom_range(0, 9);
        seq = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        build_frame(kind, plen, seq);
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = idle_len(tx_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
    endtask

    task automatic send_frame(int unsigned limit, inout int unsigned sent);
        foreach (tx_frame[k]) begin
            if (sent >= limit) break;
            send_byte(tx_frame[k]);
            sent++;
        end
    endtask

    task automatic wait_idle();
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic apb_write(logic [0:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(int unsigned fb, bit wen);
        wait_idle();
        apb_write(REG_FRAME_BYTES, fb);
        apb_write(REG_WHITEN_ENABLE, {31'd0, wen});
        settings_used++;
    endtask

    task automatic run_phase(int unsigned fb, bit wen, int unsigned budget,
                             int snd_mode, int rcv_mode, bit pressure);
        int unsigned sent;
        set_config(fb, wen);
        tx_mode = snd_mode;
        rx_mode = rcv_mode;
        if (pressure) hold_req = 1'b1;
        sent = 0;
        while (sent < budget) begin
            if (sb.frame_pos != 0) begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end else begin
                random_frame();
                send_frame(budget, sent);
            end
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        int unsigned sent;
        int unsigned phase_fb[10];
        sb            = new(MAX_FRAME);
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_rx_byte     = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        tx_mode       = 0;
        rx_mode       = 0;
        hold_req      = 1'b0;
        settings_used = 0;
        phase_fb      = '{0, 13, 12, 14, 21, 33, 64, 1, 100, 0};
        phase_fb[9]   = $urandom_range(13, 160);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Shortest frames: an empty payload with an all-ones sequence, then one payload byte.
        set_config(13, 1'b0);
        sent = 0;
        build_frame(FR_GOOD, 0, 32'hFFFF_FFFF);
        send_frame(13, sent);
        sent = 0;
        build_frame(FR_GOOD, 1, 32'h0000_0000);
        send_frame(13, sent);
        s_valid <= 1'b0;

        for (int p = 0; p < 10; p++) begin
            run_phase(phase_fb[p], p[0], $urandom_range(70, 90),
                      (p == 0 || p == 3) ? 0 : $urandom_range(0, 1),
                      (p == 0) ? 0 : $urandom_range(0, 1), p == 3);
        end
        run_phase(4095, 1'b1, 120, 1, 1, 1'b0);
        run_phase(13, 1'b0, 60, 1, 1, 1'b0);

        wait_idle();
        repeat (LATENCY + 4) @(posedge aclk);
        if (sb.awaited.size() != 0) sb.failures++;
        $display("Checked %0d results over %0d register settings, %0d payload bytes streamed.",
                 sb.checked, settings_used, sb.payload_seen);
        $display("Frames ended: %0d ok, %0d bad magic, %0d length too large, %0d CRC mismatch.",
                 sb.status_count[ST_OK], sb.status_count[ST_BAD_MAGIC],
                 sb.status_count[ST_BAD_LEN], sb.status_count[ST_BAD_CRC]);
        if (sb.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        int stall;
        fdc_result_t got;
        m_ready = 1'b0;
        stall   = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = '{payload_valid: m_payload_valid, payload_byte: m_payload_byte,
                        frame_done: m_frame_done, frame_status: m_frame_status,
                        payload_length: m_payload_length,
                        sequence_number: m_sequence_number};
                sb.check_result(got);
            end
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (stall == 0) begin
                stall = idle_len(rx_mode);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/fdc_pkg.sv
rtl/fdc_apb_regs.sv
rtl/fdc_frame_core.sv
rtl/frame_decoder_crc32_dewhiten.sv
tb/fdc_frame_check_pkg.sv
tb/frame_decoder_crc32_dewhiten_test.sv
